>>> src/display_frame_command_decoder_macros.svh
// ----------------------------------------------------------------------------
// Display frame command decoder assertion macros
// Shared property macros for the checker of the frame decoder.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_FRAME_COMMAND_DECODER_MACROS_SVH
`define DISPLAY_FRAME_COMMAND_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DFCD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame decoder check failed");

// Next-cycle implication, disabled during reset.
`define DFCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame decoder check failed");

`endif

>>> src/dfcd_pkg.sv
// ----------------------------------------------------------------------------
// Display frame command decoder package
// Types, codes and constants shared by the frame decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfcd_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h5A;
  localparam logic [7:0] HDR_SECOND = 8'hA5;
  localparam logic [7:0] TX_END     = 8'hFF;

  localparam logic [7:0] HEX_SPLIT      = 8'd59;
  localparam logic [7:0] HEX_DIGIT_BASE = 8'd48;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd87;

  localparam logic [15:0] PWM_BASE      = 16'h5000;
  localparam logic [15:0] PWM_LAST      = 16'h5031;
  localparam logic [15:0] CAN_TX_ADDR   = 16'h5032;
  localparam logic [15:0] CAN_ID_ADDR   = 16'h5064;
  localparam logic [15:0] CAN_BAUD_ADDR = 16'h5080;
  localparam logic [15:0] RS_TX_ADDR    = 16'h5096;
  localparam logic [15:0] RS_BAUD_ADDR  = 16'h5128;

  localparam logic [5:0] PWM_RESTART_MAX = 6'd28;

  localparam int MAX_TX_BYTES = 16;
  localparam int TX_CNT_W     = $clog2(MAX_TX_BYTES + 1);

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HDR2,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef enum logic [2:0] {
    EV_PWM_FREQ,
    EV_PWM_DUTY,
    EV_CAN_ID,
    EV_CAN_BAUD,
    EV_CAN_BYTE,
    EV_RS485_BAUD,
    EV_RS485_BYTE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  channel;
    logic [31:0] value;
    logic        restart;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    return (c < HEX_SPLIT) ? c - HEX_DIGIT_BASE : c - HEX_ALPHA_BASE;
  endfunction

  function automatic logic [7:0] pack_pair(input logic [7:0] hi, input logic [7:0] lo);
    return {hi[3:0], 4'b0000} + lo;
  endfunction

  function automatic result_t make_result(input kind_t kind, input logic [2:0] channel,
                                          input logic [31:0] value, input logic restart,
                                          input logic last);
    result_t r;
    r.kind    = kind;
    r.channel = channel;
    r.value   = value;
    r.restart = restart;
    r.last    = last;
    return r;
  endfunction

  function automatic push_t push_add(input push_t p, input result_t r);
    push_t q;
    q = p;
    if (p.count == 2'd0) begin
      q.first = r;
    end else begin
      q.second = r;
    end
    q.count = p.count + 2'd1;
    return q;
  endfunction

endpackage

>>> src/display_frame_command_decoder.sv
// ----------------------------------------------------------------------------
// Display frame command decoder
// Takes one received byte per item at up to one item per clock cycle. Frames
// start with 5A A5 and a length byte, and the body carries a command, a 16-bit
// address, a word count and data. Each byte is decoded in the cycle it is
// accepted, and its results are registered into a four-entry result queue,
// from which they drain at one per cycle while out_ready is high. A byte
// causes at most two results; in_ready is low while the queue has fewer than
// two free entries, so input stalls only when the output side is backed up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module display_frame_command_decoder import dfcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_kind,
  output logic [2:0]  channel,
  output logic [31:0] value,
  output logic        restart_timer,
  output logic        last
);

  push_t   push;
  result_t head;
  logic    room;
  logic    fire;

  assign in_ready = room;
  assign fire     = in_valid && in_ready;

  dfcd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (rx_byte),
    .push    (push)
  );

  dfcd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign event_kind    = head.kind;
  assign channel       = head.channel;
  assign value         = head.value;
  assign restart_timer = head.restart;
  assign last          = head.last;

endmodule

>>> src/dfcd_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Tracks the frame phase and body fields, packs transmit characters and
// produces up to two result items for each accepted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfcd_parser import dfcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output push_t      push
);

  phase_t                phase, phase_next;
  logic [7:0]            body_length, body_length_next;
  logic [7:0]            body_count, body_count_next;
  logic [15:0]           frame_address, frame_address_next;
  logic [31:0]           data_word, data_word_next;
  logic [3:0]            pend_nib, pend_nib_next;
  logic                  pend_valid, pend_valid_next;
  logic [7:0]            held_byte, held_byte_next;
  logic                  held_valid, held_valid_next;
  logic                  string_ended, string_ended_next;
  logic [TX_CNT_W-1:0]   tx_count, tx_count_next;
  logic                  can_ready, can_ready_next;
  logic                  serial_ready, serial_ready_next;

  logic [7:0] body_count_inc;
  logic       frame_done;
  logic [7:0] rx_hex;
  logic       can_tx, rs_tx;
  kind_t      tx_kind;

  assign body_count_inc = body_count + 8'd1;
  assign frame_done     = body_count_inc >= body_length;
  assign rx_hex         = hex_value(rx_byte);
  assign can_tx         = (frame_address == CAN_TX_ADDR) && can_ready;
  assign rs_tx          = (frame_address == RS_TX_ADDR) && serial_ready;
  assign tx_kind        = can_tx ? EV_CAN_BYTE : EV_RS485_BYTE;

  always_comb begin
    phase_next = phase;
    if (fire) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == HDR_FIRST) phase_next = PH_HDR2;
        end
        PH_HDR2: begin
          if (rx_byte == HDR_SECOND) phase_next = PH_LEN;
          else if (rx_byte != HDR_FIRST) phase_next = PH_HUNT;
        end
        PH_LEN: begin
          phase_next = (rx_byte == 8'd0) ? PH_HUNT : PH_BODY;
        end
        PH_BODY: begin
          if (frame_done) phase_next = PH_HUNT;
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    logic [5:0]  off;
    logic [2:0]  pwm_ch;
    logic        pwm_restart;
    logic [31:0] id_value;
    kind_t       end_kind;

    off         = '0;
    pwm_ch      = '0;
    pwm_restart = 1'b0;
    id_value    = '0;
    end_kind    = EV_CAN_BYTE;

    body_length_next   = body_length;
    body_count_next    = body_count;
    frame_address_next = frame_address;
    data_word_next     = data_word;
    pend_nib_next      = pend_nib;
    pend_valid_next    = pend_valid;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    string_ended_next  = string_ended;
    tx_count_next      = tx_count;
    can_ready_next     = can_ready;
    serial_ready_next  = serial_ready;
    push               = '0;

    if (fire && phase == PH_LEN) begin
      body_length_next   = rx_byte;
      body_count_next    = '0;
      frame_address_next = '0;
      data_word_next     = '0;
      pend_nib_next      = '0;
      pend_valid_next    = 1'b0;
      held_byte_next     = '0;
      held_valid_next    = 1'b0;
      string_ended_next  = 1'b0;
      tx_count_next      = '0;
    end else if (fire && phase == PH_BODY) begin
      if (body_count == 8'd1) begin
        frame_address_next = {rx_byte, 8'h00};
      end else if (body_count == 8'd2) begin
        frame_address_next = {frame_address[15:8], rx_byte};
      end else if (body_count >= 8'd4) begin
        case (body_count)
          8'd4:    data_word_next[31:24] = rx_byte;
          8'd5:    data_word_next[23:16] = rx_byte;
          8'd6:    data_word_next[15:8]  = rx_byte;
          8'd7:    data_word_next[7:0]   = rx_byte;
          default: ;
        endcase
        if ((can_tx || rs_tx) && !string_ended) begin
          if (rx_byte == TX_END) begin
            if (held_valid_next) begin
              push = push_add(push, make_result(tx_kind, 3'd0, {24'd0, held_byte_next},
                                                1'b0, !pend_valid_next));
            end
            if (pend_valid_next) begin
              push = push_add(push, make_result(tx_kind, 3'd0,
                                                {24'd0, pend_nib_next, 4'b0000}, 1'b0, 1'b1));
            end
            held_valid_next   = 1'b0;
            pend_valid_next   = 1'b0;
            string_ended_next = 1'b1;
          end else if (!pend_valid) begin
            if (tx_count < TX_CNT_W'(MAX_TX_BYTES)) begin
              pend_nib_next   = rx_hex[3:0];
              pend_valid_next = 1'b1;
            end
          end else begin
            pend_valid_next = 1'b0;
            tx_count_next   = tx_count + TX_CNT_W'(1);
            if (held_valid) begin
              push = push_add(push, make_result(tx_kind, 3'd0, {24'd0, held_byte},
                                                1'b0, 1'b0));
            end
            held_byte_next  = pack_pair({4'b0000, pend_nib}, rx_hex);
            held_valid_next = 1'b1;
          end
        end
      end

      body_count_next = body_count_inc;

      if (frame_done) begin
        if (frame_address_next >= PWM_BASE && frame_address_next <= PWM_LAST) begin
          off         = 6'(frame_address_next - PWM_BASE);
          pwm_restart = (off[1:0] == 2'b00) && (off <= PWM_RESTART_MAX);
          if (off[2:0] == 3'b000) begin
            pwm_ch = off[5:3];
            push = push_add(push, make_result(EV_PWM_FREQ, pwm_ch,
                                              {16'd0, data_word_next[31:16]},
                                              pwm_restart, 1'b1));
          end else begin
            pwm_ch = (off < 6'd4) ? 3'd0 : 3'((off - 6'd4) >> 3);
            push = push_add(push, make_result(EV_PWM_DUTY, pwm_ch,
                                              {16'd0, data_word_next[31:16]},
                                              pwm_restart, 1'b1));
          end
        end else if (frame_address_next == CAN_ID_ADDR) begin
          id_value = {24'd0, pack_pair(hex_value(data_word_next[31:24]),
                                       hex_value(data_word_next[23:16]))};
          push = push_add(push, make_result(EV_CAN_ID, 3'd0, id_value, 1'b0, 1'b1));
        end else if (frame_address_next == CAN_BAUD_ADDR) begin
          can_ready_next = data_word_next != 32'd0;
          push = push_add(push, make_result(EV_CAN_BAUD, 3'd0, data_word_next, 1'b0, 1'b1));
        end else if (frame_address_next == RS_BAUD_ADDR) begin
          serial_ready_next = data_word_next != 32'd0;
          push = push_add(push, make_result(EV_RS485_BAUD, 3'd0, data_word_next,
                                            1'b0, 1'b1));
        end else if (((frame_address_next == CAN_TX_ADDR) && can_ready) ||
                     ((frame_address_next == RS_TX_ADDR) && serial_ready)) begin
          end_kind = (frame_address_next == CAN_TX_ADDR) ? EV_CAN_BYTE : EV_RS485_BYTE;
          if (!string_ended_next) begin
            if (held_valid_next) begin
              push = push_add(push, make_result(end_kind, 3'd0, {24'd0, held_byte_next},
                                                1'b0, !pend_valid_next));
            end
            if (pend_valid_next) begin
              push = push_add(push, make_result(end_kind, 3'd0,
                                                {24'd0, pend_nib_next, 4'b0000}, 1'b0, 1'b1));
            end
            held_valid_next   = 1'b0;
            pend_valid_next   = 1'b0;
            string_ended_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      body_length   <= '0;
      body_count    <= '0;
      frame_address <= '0;
      data_word     <= '0;
      pend_nib      <= '0;
      pend_valid    <= 1'b0;
      held_byte     <= '0;
      held_valid    <= 1'b0;
      string_ended  <= 1'b0;
      tx_count      <= '0;
      can_ready     <= 1'b0;
      serial_ready  <= 1'b0;
    end else begin
      phase         <= phase_next;
      body_length   <= body_length_next;
      body_count    <= body_count_next;
      frame_address <= frame_address_next;
      data_word     <= data_word_next;
      pend_nib      <= pend_nib_next;
      pend_valid    <= pend_valid_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      string_ended  <= string_ended_next;
      tx_count      <= tx_count_next;
      can_ready     <= can_ready_next;
      serial_ready  <= serial_ready_next;
    end
  end

endmodule

>>> src/dfcd_result_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two result items per cycle and hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfcd_result_fifo import dfcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  result_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign room      = count <= QCNT_W'(QDEPTH - 2);
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wptr + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(push.count);
      rptr  <= rptr + QPTR_W'(pop);
      count <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

endmodule

>>> src/dfcd_checker.sv
// ----------------------------------------------------------------------------
// Frame decoder checker
// Port-level checks on the result stream of the frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "display_frame_command_decoder_macros.svh"

module dfcd_checker import dfcd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_kind,
  input logic [2:0]  channel,
  input logic [31:0] value,
  input logic        restart_timer
);

  logic stalled;
  logic pwm_kind;
  logic byte_kind;

  assign stalled   = out_valid && !out_ready;
  assign pwm_kind  = (event_kind == EV_PWM_FREQ) || (event_kind == EV_PWM_DUTY);
  assign byte_kind = (event_kind == EV_CAN_ID) || (event_kind == EV_CAN_BYTE) ||
                     (event_kind == EV_RS485_BYTE);

  `DFCD_ASSERT_NEXT(a_out_hold, clk, rst, stalled, out_valid && $stable({event_kind, value}))
  `DFCD_ASSERT_NOW(a_channel_pwm_only, clk, rst, out_valid && !pwm_kind, channel == 3'd0)
  `DFCD_ASSERT_NOW(a_restart_pwm_only, clk, rst, out_valid && restart_timer, pwm_kind)
  `DFCD_ASSERT_NOW(a_byte_range, clk, rst, out_valid && byte_kind, value[31:8] == 24'd0)

endmodule

bind display_frame_command_decoder dfcd_checker u_dfcd_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display frame command decoder testbench
// Sends a byte stream of directed and random display frames through the
// decoder. The stream mixes PWM, CAN ID, baud and transmit frames with noise,
// bad headers and cut-short frames. A model of the frame parser in this file
// predicts every event, and the monitor checks each output item against the
// oldest predicted event. Both sides insert random idle cycles, and the
// receiver also holds off for long stretches so that the input stalls.
// ----------------------------------------------------------------------------

module testbench;
  import dfcd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_kind;
  logic [2:0]  channel;
  logic [31:0] value;
  logic        restart_timer;
  logic        last;

  logic [7:0]  rx_stream[$];
  logic [7:0]  frame_payload[$];
  result_t     predicted_events[$];

  int   error_count = 0;
  int   accepted_bytes = 0;
  int   in_wait = 0;
  int   out_wait = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  logic sink_hold = 1'b0;

  phase_t      fr_phase;
  logic [7:0]  fr_len;
  logic [7:0]  fr_cnt;
  logic [15:0] fr_addr;
  logic [31:0] fr_word;
  logic [7:0]  nib;
  bit          nib_valid;
  logic [7:0]  held;
  bit          held_valid;
  bit          run_done;
  int          tx_bytes;
  bit          can_up;
  bit          rs_up;

  display_frame_command_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .channel      (channel),
    .value        (value),
    .restart_timer(restart_timer),
    .last         (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] hex_of(input logic [7:0] c);
    return (c < 8'd59) ? c - 8'd48 : c - 8'd87;
  endfunction

  function automatic int draw_wait(input bit calm);
    if (calm || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return int'($urandom_range(0, 12));
  endfunction

  task automatic push_event(input kind_t k, input logic [2:0] ch, input logic [31:0] v,
                            input logic rs, input logic lst);
    result_t e;
    e.kind    = k;
    e.channel = ch;
    e.value   = v;
    e.restart = rs;
    e.last    = lst;
    predicted_events.push_back(e);
  endtask

  task automatic open_frame(input logic [7:0] len);
    fr_len     = len;
    fr_cnt     = 8'd0;
    fr_addr    = 16'h0000;
    fr_word    = 32'h0;
    nib        = 8'h00;
    nib_valid  = 1'b0;
    held       = 8'h00;
    held_valid = 1'b0;
    run_done   = 1'b0;
    tx_bytes   = 0;
  endtask

  task automatic flush_run(input kind_t k);
    if (held_valid) begin
      push_event(k, 3'd0, {24'h0, held}, 1'b0, !nib_valid);
    end
    if (nib_valid) begin
      push_event(k, 3'd0, {24'h0, nib[3:0], 4'h0}, 1'b0, 1'b1);
    end
    held_valid = 1'b0;
    nib_valid  = 1'b0;
    run_done   = 1'b1;
  endtask

  task automatic close_frame();
    int         off;
    logic       rs;
    logic [7:0] hi;
    logic [7:0] lo;
    if (fr_addr >= PWM_BASE && fr_addr <= PWM_LAST) begin
      off = int'(fr_addr - PWM_BASE);
      rs  = (off % 4 == 0) && (off <= int'(PWM_RESTART_MAX));
      if (off % 8 == 0) begin
        push_event(EV_PWM_FREQ, 3'(off / 8), {16'h0, fr_word[31:16]}, rs, 1'b1);
      end else begin
        push_event(EV_PWM_DUTY, (off < 4) ? 3'd0 : 3'((off - 4) / 8),
                   {16'h0, fr_word[31:16]}, rs, 1'b1);
      end
    end else if (fr_addr == CAN_ID_ADDR) begin
      hi = hex_of(fr_word[31:24]);
      lo = hex_of(fr_word[23:16]);
      push_event(EV_CAN_ID, 3'd0, {24'h0, {hi[3:0], 4'h0} + lo}, 1'b0, 1'b1);
    end else if (fr_addr == CAN_BAUD_ADDR) begin
      can_up = fr_word != 32'h0;
      push_event(EV_CAN_BAUD, 3'd0, fr_word, 1'b0, 1'b1);
    end else if (fr_addr == RS_BAUD_ADDR) begin
      rs_up = fr_word != 32'h0;
      push_event(EV_RS485_BAUD, 3'd0, fr_word, 1'b0, 1'b1);
    end else if ((fr_addr == CAN_TX_ADDR && can_up) || (fr_addr == RS_TX_ADDR && rs_up)) begin
      if (!run_done) begin
        flush_run((fr_addr == CAN_TX_ADDR) ? EV_CAN_BYTE : EV_RS485_BYTE);
      end
    end
  endtask

  task automatic decode_rx_byte(input logic [7:0] b);
    int         k;
    bit         can_tx;
    bit         rs_tx;
    kind_t      run_kind;
    logic [7:0] pair_byte;
    case (fr_phase)
      PH_HUNT: begin
        if (b == HDR_FIRST) fr_phase = PH_HDR2;
      end
      PH_HDR2: begin
        if (b == HDR_SECOND) fr_phase = PH_LEN;
        else if (b != HDR_FIRST) fr_phase = PH_HUNT;
      end
      PH_LEN: begin
        open_frame(b);
        if (b == 8'd0) begin
          close_frame();
          fr_phase = PH_HUNT;
        end else begin
          fr_phase = PH_BODY;
        end
      end
      default: begin
        if (fr_cnt == 8'd1) begin
          fr_addr = {b, 8'h00};
        end else if (fr_cnt == 8'd2) begin
          fr_addr[7:0] = b;
        end else if (fr_cnt >= 8'd4) begin
          k      = int'(fr_cnt) - 4;
          can_tx = (fr_addr == CAN_TX_ADDR) && can_up;
          rs_tx  = (fr_addr == RS_TX_ADDR) && rs_up;
          if (k < 4) fr_word = fr_word | ({24'h0, b} << (24 - 8 * k));
          if ((can_tx || rs_tx) && !run_done) begin
            run_kind = can_tx ? EV_CAN_BYTE : EV_RS485_BYTE;
            if (b == TX_END) begin
              flush_run(run_kind);
            end else if (!nib_valid) begin
              if (tx_bytes < MAX_TX_BYTES) begin
                nib       = hex_of(b);
                nib_valid = 1'b1;
              end
            end else begin
              pair_byte = {nib[3:0], 4'h0} + hex_of(b);
              nib_valid = 1'b0;
              tx_bytes++;
              if (held_valid) push_event(run_kind, 3'd0, {24'h0, held}, 1'b0, 1'b0);
              held       = pair_byte;
              held_valid = 1'b1;
            end
          end
        end
        fr_cnt++;
        if (fr_cnt >= fr_len) begin
          close_frame();
          fr_phase = PH_HUNT;
        end
      end
    endcase
  endtask

  function automatic logic [7:0] hex_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 8'h30 + 8'($urandom_range(0, 9));
      6, 7:             return 8'h61 + 8'($urandom_range(0, 5));
      8:                return 8'h41 + 8'($urandom_range(0, 5));
      default:          return 8'($urandom_range(0, 254));
    endcase
  endfunction

  function automatic int cut_len(input int n);
    if ($urandom_range(0, 5) == 0) begin
      return int'($urandom_range(0, n + 2));
    end
    return n;
  endfunction

  // Body is command, address, word count and payload; only len bytes of it are sent,
  // so a longer length swallows the bytes that follow.
  task automatic send_frame(input logic [15:0] addr, input int len);
    logic [7:0] body[$];
    body = {8'h82, addr[15:8], addr[7:0], 8'(frame_payload.size() / 2)};
    foreach (frame_payload[i]) body.push_back(frame_payload[i]);
    rx_stream.push_back(HDR_FIRST);
    rx_stream.push_back(HDR_SECOND);
    rx_stream.push_back(8'(len));
    for (int i = 0; i < len && i < body.size(); i++) rx_stream.push_back(body[i]);
    frame_payload.delete();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'h00;
      in_wait  <= 0;
      fr_phase = PH_HUNT;
      can_up   = 1'b0;
      rs_up    = 1'b0;
      open_frame(8'd0);
    end else begin
      if (in_valid && in_ready) begin
        decode_rx_byte(rx_byte);
        accepted_bytes++;
      end
      if (!in_valid || in_ready) begin
        if (in_wait > 0) begin
          in_valid <= 1'b0;
          in_wait  <= in_wait - 1;
        end else if (rx_stream.size() > 0) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_stream.pop_front();
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          in_wait  <= draw_wait(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    int      w;
    result_t exp_ev;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else begin
      w = 0;
      if (out_valid && out_ready) begin
        if (predicted_events.size() == 0) begin
          $display("%0t: unexpected event kind %0d value %0h", $time, event_kind, value);
          error_count++;
        end else begin
          exp_ev = predicted_events.pop_front();
          if (event_kind !== exp_ev.kind) begin
            $display("%0t: event_kind expected %0d got %0d", $time, exp_ev.kind, event_kind);
            error_count++;
          end
          if (channel !== exp_ev.channel) begin
            $display("%0t: channel expected %0d got %0d", $time, exp_ev.channel, channel);
            error_count++;
          end
          if (value !== exp_ev.value) begin
            $display("%0t: value expected %0h got %0h", $time, exp_ev.value, value);
            error_count++;
          end
          if (restart_timer !== exp_ev.restart) begin
            $display("%0t: restart_timer expected %0b got %0b", $time, exp_ev.restart,
                     restart_timer);
            error_count++;
          end
          if (last !== exp_ev.last) begin
            $display("%0t: last expected %0b got %0b", $time, exp_ev.last, last);
            error_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        w = draw_wait(out_calm);
      end
      if (sink_hold) begin
        out_ready <= 1'b0;
      end else if (w > 0) begin
        out_ready <= 1'b0;
        out_wait  <= w - 1;
      end else if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait  <= out_wait - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long receiver stalls while the sender keeps going, so the result queue fills.
  initial begin
    while (accepted_bytes < 100) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (80) @(posedge clk);
    sink_hold <= 1'b0;
    while (accepted_bytes < 300) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (80) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin
    int          pick;
    int          n_chars;
    logic [31:0] w;
    rx_stream = {8'h00, HDR_FIRST, HDR_FIRST, 8'h33, HDR_FIRST, HDR_FIRST, HDR_SECOND,
                 8'h00, 8'hFF};
    frame_payload = {8'h31, 8'h32};
    send_frame(CAN_TX_ADDR, 6);
    frame_payload = {8'h00, 8'h01, 8'hC2, 8'h00};
    send_frame(CAN_BAUD_ADDR, 8);
    frame_payload = {8'h31, 8'h32, 8'h61, TX_END, 8'h33};
    send_frame(CAN_TX_ADDR, 9);
    frame_payload = {8'hFF, 8'hFF};
    send_frame(PWM_LAST, 6);

    while (rx_stream.size() < 400) begin
      pick = int'($urandom_range(0, 19));
      if (pick < 2) begin
        repeat ($urandom_range(1, 3)) rx_stream.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 5) begin
        case ($urandom_range(0, 3))
          0:       w = 32'h0;
          1:       w = 32'hFFFF_FFFF;
          default: w = $urandom;
        endcase
        frame_payload = {w[31:24], w[23:16]};
        send_frame(PWM_BASE + 16'($urandom_range(0, 49)), cut_len(6));
      end else if (pick < 6) begin
        frame_payload = {hex_char(), hex_char()};
        send_frame(CAN_ID_ADDR, cut_len(6));
      end else if (pick < 10) begin
        w = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
        frame_payload = {w[31:24], w[23:16], w[15:8], w[7:0]};
        send_frame((pick < 8) ? CAN_BAUD_ADDR : RS_BAUD_ADDR, cut_len(8));
      end else if (pick < 18) begin
        n_chars = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 8))
                                              : int'($urandom_range(0, 40));
        repeat (n_chars) frame_payload.push_back(hex_char());
        if ($urandom_range(0, 3) != 0) begin
          frame_payload.push_back(TX_END);
          repeat ($urandom_range(0, 3)) frame_payload.push_back(hex_char());
        end
        send_frame((pick < 14) ? CAN_TX_ADDR : RS_TX_ADDR, cut_len(frame_payload.size() + 4));
      end else if (pick < 19) begin
        repeat ($urandom_range(0, 6)) frame_payload.push_back(8'($urandom_range(0, 255)));
        send_frame(16'($urandom), cut_len(frame_payload.size() + 4));
      end else begin
        rx_stream.push_back(HDR_FIRST);
        rx_stream.push_back(8'($urandom_range(0, 255)));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (rx_stream.size() > 0 || in_valid) @(posedge clk);
    while (predicted_events.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (predicted_events.size() != 0) begin
      $display("%0t: %0d predicted events never arrived", $time, predicted_events.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/dfcd_pkg.sv
src/dfcd_parser.sv
src/dfcd_result_fifo.sv
src/display_frame_command_decoder.sv
src/dfcd_checker.sv
tb/sv/testbench.sv
